// File: rtl/alls_pkg.sv
// Shared types and constants for the array linked list set.
package alls_pkg;

	localparam int MAX_HANDLES = 256;
	localparam int IDX_W       = $clog2(MAX_HANDLES);
	localparam int HDL_W       = 9;
	localparam int CAP_W       = 9;

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [HDL_W-1:0] hdl_t;
	typedef logic [CAP_W-1:0]        cap_t;

	localparam hdl_t HDL_NONE  = '1;
	localparam cap_t CAP_RESET = cap_t'(256);
	localparam cap_t CAP_MAX   = cap_t'(MAX_HANDLES);

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_HEAD   = 2'd2,
		FUNC_NEXT   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_NEXT,
		ST_CLEAR,
		ST_RESP
	} state_t;

	// one access to the link table per cycle
	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		hdl_t wr_data;
	} mem_req_t;

endpackage

// File: rtl/alls_link_mem.sv
// Link table: synchronous memory with per-entry valid bits, empty entries read as none.
module alls_link_mem (
	input  logic            clk,
	input  logic            arst_n,
	input  alls_pkg::mem_req_t req,
	output alls_pkg::hdl_t  rd_data
);
	import alls_pkg::*;

	hdl_t                   mem [MAX_HANDLES];
	logic [MAX_HANDLES-1:0] vld_q;
	hdl_t                   rd_raw_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : HDL_NONE;

endmodule

// File: rtl/alls_engine.sv
// Operation sequencer: head register, list walk and result register.
module alls_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  alls_pkg::cap_t  eff_cap,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic [1:0]      func,
	input  alls_pkg::hdl_t  handle,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output alls_pkg::hdl_t  value,
	output logic            found,
	output alls_pkg::mem_req_t mem_req,
	input  alls_pkg::hdl_t  rd_data
);
	import alls_pkg::*;

	state_t state_q, state_d;
	hdl_t   head_q;
	idx_t   h_q;
	hdl_t   cur_q;
	idx_t   prev_q;
	logic   prev_vld_q;
	cap_t   steps_q;
	hdl_t   res_value_q;
	logic   res_found_q;
	logic   res_mem_q;
	logic   out_valid_q;
	hdl_t   out_value_q;
	logic   out_found_q;

	logic   accept;
	logic   in_range;
	logic   out_free;
	logic   cur_hit;
	func_t  op;

	assign op        = func_t'(func);
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_range  = !handle[HDL_W-1] && (cap_t'(handle[IDX_W-1:0]) < eff_cap);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign cur_hit   = (cur_q[IDX_W-1:0] == h_q);

	// The sequencer issues at most one table access per cycle and never reads an
	// entry in the cycle it writes it, so no forwarding is needed.
	always_comb begin
		state_d = state_q;
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_RESP;
					unique case (op)
						FUNC_ADD: begin
							if (in_range) begin
								mem_req.wr_en   = 1'b1;
								mem_req.wr_addr = handle[IDX_W-1:0];
								mem_req.wr_data = head_q;
							end
						end
						FUNC_REMOVE: begin
							if (in_range) begin
								state_d = ST_WALK;
							end
						end
						FUNC_HEAD: begin
							state_d = ST_RESP;
						end
						FUNC_NEXT: begin
							if (in_range) begin
								mem_req.rd_en   = 1'b1;
								mem_req.rd_addr = handle[IDX_W-1:0];
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_WALK: begin
				// stop at the end of the list or once the capacity is spent
				if (steps_q >= eff_cap || cur_q[HDL_W-1]) begin
					state_d = ST_RESP;
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = cur_q[IDX_W-1:0];
					state_d         = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (cur_hit) begin
					if (prev_vld_q) begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = prev_q;
						mem_req.wr_data = rd_data;
					end
					state_d = ST_CLEAR;
				end else begin
					state_d = ST_WALK;
				end
			end
			ST_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = h_q;
				mem_req.wr_data = HDL_NONE;
				state_d         = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= HDL_NONE;
			prev_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_vld_q <= 1'b0;
				if (op == FUNC_ADD && in_range) begin
					head_q <= handle;
				end
			end
			if (state_q == ST_NEXT) begin
				if (cur_hit) begin
					if (!prev_vld_q) begin
						head_q <= rd_data;
					end
				end else begin
					prev_vld_q <= 1'b1;
				end
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_q         <= handle[IDX_W-1:0];
			cur_q       <= head_q;
			steps_q     <= '0;
			res_mem_q   <= (op == FUNC_NEXT) && in_range;
			res_found_q <= (op == FUNC_HEAD) || ((op == FUNC_ADD || op == FUNC_NEXT) && in_range);
			if (op == FUNC_HEAD) begin
				res_value_q <= head_q;
			end else if (op == FUNC_ADD && in_range) begin
				res_value_q <= handle;
			end else begin
				res_value_q <= HDL_NONE;
			end
		end
		if (state_q == ST_NEXT) begin
			if (cur_hit) begin
				res_found_q <= 1'b1;
			end else begin
				prev_q  <= cur_q[IDX_W-1:0];
				cur_q   <= rd_data;
				steps_q <= steps_q + cap_t'(1);
			end
		end
		if (state_q == ST_RESP && out_free) begin
			out_value_q <= res_mem_q ? rd_data : res_value_q;
			out_found_q <= res_found_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign value     = out_value_q;
	assign found     = out_found_q;

endmodule

// File: rtl/array_linked_list_set.sv
// Array linked list set: singly linked list of handles kept in a link table.
//
// Requests arrive on req_valid/req_stall with func and handle; results leave on
// rsp_valid/rsp_stall with value and found, one result per request, in order.
// func: add pushes a handle at the head, remove unlinks it, head returns the
// first handle, next returns a handle's successor.
// One request is in flight at a time; req_stall is low only while idle.
// Add, head, successor and out-of-range requests go from accept straight to the
// response state; a new request is taken only once the result register has loaded.
// Remove walks the list through the single link-table port, reading one link per
// node; on a hit it relinks the predecessor or the head, clears the node's link and
// responds. The walk stops at the end of the list or after capacity nodes.
// The result register holds while rsp_stall is high; the sequencer waits in
// its response state until the register is free, so no result is lost.
// Reset empties the list at once: the head goes to none and the link table's
// valid bits clear, so every link reads as none until written. No sweep.
// capacity_in_use sits at APB address 0 and resets to 256; the value used saturates at the
// table depth; write it only while the block is idle.
module array_linked_list_set (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           func,
	input  logic signed [8:0]    handle,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic signed [8:0]    value,
	output logic                 found
);
	import alls_pkg::*;

	cap_t     cap_q;
	cap_t     eff_cap;
	mem_req_t mem_req;
	hdl_t     rd_data;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && !paddr[2];
	assign prdata  = paddr[2] ? 32'd0 : 32'(cap_q);
	assign eff_cap = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	alls_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_cap   (eff_cap),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.handle    (handle),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value),
		.found     (found),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	alls_link_mem u_link_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> !mem_req.rd_en)
		else $error("link table read and written in the same cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request taken while the previous one is still in flight");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result appeared without a request in flight");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the array linked list set: directed and random list operations.
module testbench;
	import alls_pkg::*;

	localparam int          LIMIT_CYCLES = 4000000;
	localparam int          LONG_HOLD    = 300;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          PHASES       = 8;
	localparam logic [2:0]  CFG_CAP_ADDR = 3'd0;

	typedef struct {
		func_t op;
		hdl_t  hdl;
	} list_req_t;

	typedef struct {
		hdl_t value;
		logic found;
	} list_rsp_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         func      = 2'd0;
	logic signed [8:0]  handle    = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic signed [8:0]  value;
	logic               found;

	list_req_t req_queue[$];
	list_rsp_t due_rsp[$];

	// predictor copy of the block's state
	cap_t list_cap;
	hdl_t list_head;
	hdl_t list_link [MAX_HANDLES];

	int   send_pct      = 0;
	int   stall_pct     = 0;
	int   hold_req_cnt  = 0;
	int   hold_seen_cnt = 0;
	int   hold_left     = 0;
	int   queued_cnt    = 0;
	int   accepted_cnt  = 0;
	int   errors        = 0;
	int   cycles        = 0;
	logic req_fire      = 1'b0;

	array_linked_list_set i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.handle    (handle),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value),
		.found     (found)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Apply one request to the predicted list and return the result it gives.
	function automatic void list_step(input func_t op, input hdl_t h, output hdl_t v,
			output logic fnd);
		int lim;
		int hi;
		int cur;
		int prev;
		int s;
		bit ok;
		lim = (list_cap > CAP_MAX) ? MAX_HANDLES : int'(list_cap);
		hi  = int'(h);
		ok  = (hi >= 0) && (hi < lim);
		v   = HDL_NONE;
		fnd = 1'b0;
		case (op)
			FUNC_ADD: begin
				if (ok) begin
					list_link[hi] = list_head;
					list_head     = h;
					v             = h;
					fnd           = 1'b1;
				end
			end
			FUNC_REMOVE: begin
				if (ok) begin
					prev = -1;
					cur  = int'(list_head);
					s    = 0;
					// bounded walk: loops made by a duplicate add end here
					while (s < lim && cur >= 0 && !fnd) begin
						if (cur == hi) begin
							if (prev < 0)
								list_head = list_link[hi];
							else
								list_link[prev] = list_link[hi];
							list_link[hi] = HDL_NONE;
							fnd = 1'b1;
						end else begin
							prev = cur;
							cur  = int'(list_link[cur]);
						end
						s++;
					end
				end
			end
			FUNC_HEAD: begin
				v   = list_head;
				fnd = 1'b1;
			end
			default: begin
				if (ok) begin
					v   = list_link[hi];
					fnd = 1'b1;
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_rsp_t want;
		hdl_t      pv;
		logic      pf;
		if (!arst_n) begin
			list_cap  = CAP_RESET;
			list_head = HDL_NONE;
			for (int i = 0; i < MAX_HANDLES; i++)
				list_link[i] = HDL_NONE;
			req_fire <= 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == CFG_CAP_ADDR)
				list_cap = cap_t'(pwdata);
			req_fire <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				list_step(func_t'(func), handle, pv, pf);
				due_rsp.push_back('{pv, pf});
				accepted_cnt++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_rsp.size() == 0) begin
					$error("result with none due: value %0d found %0b", value, found);
					errors++;
				end else begin
					want = due_rsp.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, value);
						errors++;
					end
					if (found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, found);
						errors++;
					end
				end
			end
		end
	end

	// Request driver: advance only once the current request has been taken.
	always @(negedge clk) begin
		list_req_t nxt;
		if (arst_n && (!req_valid || req_fire)) begin
			if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_pct) begin
				nxt = req_queue.pop_front();
				req_valid <= 1'b1;
				func      <= nxt.op;
				handle    <= nxt.hdl;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result side: random stalls, plus a long hold-off when asked for.
	always @(negedge clk) begin
		if (hold_seen_cnt != hold_req_cnt) begin
			hold_seen_cnt = hold_req_cnt;
			hold_left     = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic queue_req(input func_t op, input hdl_t h);
		req_queue.push_back('{op, h});
		queued_cnt++;
	endtask

	task automatic drain();
		while (accepted_cnt != queued_cnt || due_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write the capacity register, then read it back.
	task automatic write_capacity(input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_CAP_ADDR;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CAP_W-1:0] !== data[CAP_W-1:0]) begin
			$error("capacity_in_use: expected %0d, got %0d", data[CAP_W-1:0],
				prdata[CAP_W-1:0]);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int    p;
		int    n;
		int    r;
		int    cap_w;
		int    cap_eff;
		int    span;
		int    base;
		func_t op;
		hdl_t  h;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = CFG_CAP_ADDR;
		pwdata  = '0;
		arst_n  = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty list, extremes, unlink at head and tail, self loop
		queue_req(FUNC_HEAD, 9'sd0);
		queue_req(FUNC_NEXT, 9'sd0);
		queue_req(FUNC_ADD, 9'sd0);
		queue_req(FUNC_ADD, 9'sd255);
		queue_req(FUNC_ADD, -9'sd1);
		queue_req(FUNC_ADD, hdl_t'(-256));
		queue_req(FUNC_NEXT, 9'sd255);
		queue_req(FUNC_REMOVE, 9'sd7);
		queue_req(FUNC_REMOVE, 9'sd0);
		queue_req(FUNC_REMOVE, 9'sd255);
		queue_req(FUNC_ADD, 9'sd5);
		queue_req(FUNC_ADD, 9'sd5);
		queue_req(FUNC_NEXT, 9'sd5);
		queue_req(FUNC_REMOVE, 9'sd5);
		queue_req(FUNC_HEAD, -9'sd1);
		queue_req(FUNC_REMOVE, -9'sd1);
		drain();
		write_capacity(32'd0);
		queue_req(FUNC_ADD, 9'sd0);
		queue_req(FUNC_NEXT, 9'sd0);
		drain();
		write_capacity(32'd1);
		queue_req(FUNC_ADD, 9'sd0);
		queue_req(FUNC_ADD, 9'sd1);
		queue_req(FUNC_REMOVE, 9'sd0);
		drain();
		// upper data bits are junk; capacity saturates at the table depth
		write_capacity({23'($urandom_range(0, 32'h7f_ffff)), 9'd511});
		queue_req(FUNC_ADD, 9'sd255);
		queue_req(FUNC_NEXT, 9'sd255);
		queue_req(FUNC_HEAD, 9'sd3);
		drain();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: cap_w = 256;
				1: cap_w = 16;
				2: cap_w = 1;
				3: cap_w = 511;
				4: cap_w = 40;
				5: cap_w = 0;
				6: cap_w = 256;
				default: cap_w = 3;
			endcase
			write_capacity(cap_w);
			cap_eff = (cap_w > MAX_HANDLES) ? MAX_HANDLES : cap_w;
			span    = (cap_eff < 24) ? cap_eff : 24;
			case (p % 4)
				0: begin
					send_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					send_pct  = 82;
					stall_pct = 0;
				end
				2: begin
					send_pct  = 0;
					stall_pct = 82;
				end
				default: begin
					send_pct  = 7;
					stall_pct = 7;
				end
			endcase
			base = 0;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0 && cap_eff > span)
					base = $urandom_range(0, cap_eff - span);
				r = $urandom_range(0, 99);
				if (r < 75 && span > 0) begin
					// small pool of handles, so adds and removes meet each other
					h = hdl_t'(base + $urandom_range(0, span - 1));
					r = $urandom_range(0, 99);
					op = (r < 38) ? FUNC_ADD : (r < 70) ? FUNC_REMOVE :
						(r < 80) ? FUNC_HEAD : FUNC_NEXT;
				end else if (r < 85) begin
					op = func_t'($urandom_range(0, 3));
					case ($urandom_range(0, 2))
						0: h = hdl_t'(cap_eff - 1);
						1: h = hdl_t'(cap_eff);
						default: h = HDL_NONE;
					endcase
				end else begin
					op = func_t'($urandom_range(0, 3));
					h  = hdl_t'($urandom_range(0, 511));
				end
				queue_req(op, h);
			end
			if (p == 0)
				hold_req_cnt++;
			drain();
		end

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/alls_pkg.sv
rtl/alls_link_mem.sv
rtl/alls_engine.sv
rtl/array_linked_list_set.sv
sim/testbench.sv
